/* sv/radio_frame_checker_macros.svh */
// Assertion macros for the radio frame checker.
// Included by the modules that carry concurrent checks; needs nothing else.
`ifndef RADIO_FRAME_CHECKER_MACROS_SVH
`define RADIO_FRAME_CHECKER_MACROS_SVH

// Property that must hold at every clock edge out of reset.
`define RFC_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Consequent that must hold in the cycle after the antecedent.
`define RFC_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* sv/rfc_pkg.sv */
// Shared constants, status codes and beat types for the radio frame checker.
// No dependencies; every design module imports it.
package rfc_pkg;

  localparam int RFC_PAYLOAD_BYTES = 32;
  localparam int RFC_HDR_BYTES     = 3;
  localparam int RFC_SUM_SPAN      = 13;
  localparam int RFC_CSUM_BYTES    = 4;
  localparam int RFC_STAGE_DEPTH   = 10;
  localparam int RFC_SUM_W         = 12;
  localparam int RFC_CSUM_W        = 8 * RFC_CSUM_BYTES;

  localparam logic [7:0] RFC_HDR0 = 8'h59;
  localparam logic [7:0] RFC_HDR1 = 8'h4A;
  localparam logic [7:0] RFC_HDR2 = 8'h52;

  localparam logic signed [15:0] RFC_STICK_RESET = 16'sd500;

  localparam logic [1:0] RFC_ST_OK      = 2'd0;
  localparam logic [1:0] RFC_ST_NO_DATA = 2'd1;
  localparam logic [1:0] RFC_ST_HEADER  = 2'd2;
  localparam logic [1:0] RFC_ST_CSUM    = 2'd3;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       end_of_packet;
  } rfc_in_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [15:0] throttle;
    logic signed [15:0] yaw;
    logic signed [15:0] pitch;
    logic signed [15:0] roll;
    logic signed [7:0]  altitude_cmd;
    logic signed [7:0]  shutdown_cmd;
  } rfc_out_t;

  typedef struct packed {
    logic       vld;
    logic [7:0] rx_byte;
    logic       eop;
  } rfc_beat_t;

endpackage

/* sv/rfc_stream_if.sv */
// Valid/ready stream interface carrying one payload type per beat.
// Payload type is set by the instantiating level; no package needed.
interface rfc_stream_if #(parameter type payload_t = logic);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

/* sv/radio_frame_checker.sv */
// Radio frame checker: one received byte per beat, one result per packet.
// Path: input register, combinational core, output register; the registers part the sides.
// Throughput: one byte per cycle unless an end beat waits on a full output register.
// Reset (rst, synchronous): packet state cleared, held yaw/pitch/roll 500.
// Depends on rfc_pkg, rfc_stream_if, rfc_in_reg, rfc_frame_core, rfc_out_reg.
module radio_frame_checker
  import rfc_pkg::*;
#(
  parameter int PAYLOAD_BYTES = RFC_PAYLOAD_BYTES
) (
  input  logic         clk,
  input  logic         rst,
  rfc_stream_if.sink   rx,
  rfc_stream_if.source res
);

  rfc_beat_t beat;
  rfc_out_t  res_data;
  logic      consume;
  logic      res_vld;
  logic      out_free;

  rfc_in_reg u_in (
    .clk     (clk),
    .rst     (rst),
    .rx      (rx),
    .consume (consume),
    .beat    (beat)
  );

  rfc_frame_core #(
    .PAYLOAD_BYTES (PAYLOAD_BYTES)
  ) u_core (
    .clk      (clk),
    .rst      (rst),
    .beat     (beat),
    .out_free (out_free),
    .consume  (consume),
    .res_vld  (res_vld),
    .res_data (res_data)
  );

  rfc_out_reg u_out (
    .clk      (clk),
    .rst      (rst),
    .load     (res_vld),
    .data_in  (res_data),
    .res      (res),
    .out_free (out_free)
  );

endmodule

/* sv/rfc_in_reg.sv */
// Input register stage: captures one received byte beat per cycle while the core consumes it.
// Depends on rfc_pkg and rfc_stream_if.
module rfc_in_reg
  import rfc_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  rfc_stream_if.sink   rx,
  input  logic         consume,
  output rfc_beat_t    beat
);

  logic    vld;
  rfc_in_t data;

  assign rx.ready     = !vld || consume;
  assign beat.vld     = vld;
  assign beat.rx_byte = data.rx_byte;
  assign beat.eop     = data.end_of_packet;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (rx.ready) begin
      vld <= rx.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rx.ready && rx.valid) begin
      data <= rx.payload;
    end
  end

endmodule

/* sv/rfc_frame_core.sv */
// Frame checking core: position count, header check, running sum, staged
// fields and held values. Depends on rfc_pkg and the assertion macros.
`include "radio_frame_checker_macros.svh"

module rfc_frame_core
  import rfc_pkg::*;
#(
  parameter int PAYLOAD_BYTES = RFC_PAYLOAD_BYTES
) (
  input  logic      clk,
  input  logic      rst,
  input  rfc_beat_t beat,
  input  logic      out_free,
  output logic      consume,
  output logic      res_vld,
  output rfc_out_t  res_data
);

  localparam int POS_W = $clog2(PAYLOAD_BYTES + 1);

  logic [POS_W-1:0]      pos, pos_next;
  logic [RFC_SUM_W-1:0]  run_sum, sum_next;
  logic                  hdr_ok, hdr_next, hdr_final;
  logic                  first_nz, first_next;
  logic [RFC_CSUM_W-1:0] csum, csum_next;
  logic [7:0]            stage [RFC_STAGE_DEPTH];
  logic [7:0]            stage_next [RFC_STAGE_DEPTH];

  logic signed [15:0] held_throttle, held_yaw, held_pitch, held_roll;
  logic signed [7:0]  held_altitude, held_shutdown;
  logic               held_upd;
  logic [1:0]         status;
  logic               in_range;

  always_comb begin
    pos_next   = pos;
    sum_next   = run_sum;
    hdr_next   = hdr_ok;
    first_next = first_nz;
    csum_next  = csum;
    stage_next = stage;
    in_range   = pos < POS_W'(PAYLOAD_BYTES);
    if (in_range) begin
      pos_next = pos + POS_W'(1);
      if (pos == POS_W'(0)) begin
        first_next = beat.rx_byte != 8'd0;
      end
      if ((pos == POS_W'(0) && beat.rx_byte != RFC_HDR0) ||
          (pos == POS_W'(1) && beat.rx_byte != RFC_HDR1) ||
          (pos == POS_W'(2) && beat.rx_byte != RFC_HDR2)) begin
        hdr_next = 1'b0;
      end
      if (pos < POS_W'(RFC_SUM_SPAN)) begin
        sum_next = run_sum + RFC_SUM_W'(beat.rx_byte);
      end
      for (int i = 0; i < RFC_STAGE_DEPTH; i++) begin
        if (pos == POS_W'(i + RFC_HDR_BYTES)) begin
          stage_next[i] = beat.rx_byte;
        end
      end
      for (int j = 0; j < RFC_CSUM_BYTES; j++) begin
        if (pos == POS_W'(j + RFC_SUM_SPAN)) begin
          csum_next[8 * (RFC_CSUM_BYTES - 1 - j) +: 8] = beat.rx_byte;
        end
      end
    end

    hdr_final = hdr_next && (pos_next >= POS_W'(RFC_HDR_BYTES));

    if (!first_next) begin
      status = RFC_ST_NO_DATA;
    end else if (!hdr_final) begin
      status = RFC_ST_HEADER;
    end else if (csum_next != RFC_CSUM_W'(sum_next)) begin
      status = RFC_ST_CSUM;
    end else begin
      status = RFC_ST_OK;
    end

    consume  = beat.vld && (!beat.eop || out_free);
    res_vld  = consume && beat.eop;
    held_upd = res_vld && (status == RFC_ST_OK);

    res_data.status = status;
    if (status == RFC_ST_OK) begin
      res_data.throttle     = {stage_next[0], stage_next[1]};
      res_data.yaw          = {stage_next[2], stage_next[3]};
      res_data.pitch        = {stage_next[4], stage_next[5]};
      res_data.roll         = {stage_next[6], stage_next[7]};
      res_data.altitude_cmd = stage_next[8];
      res_data.shutdown_cmd = stage_next[9];
    end else begin
      res_data.throttle     = held_throttle;
      res_data.yaw          = held_yaw;
      res_data.pitch        = held_pitch;
      res_data.roll         = held_roll;
      res_data.altitude_cmd = held_altitude;
      res_data.shutdown_cmd = held_shutdown;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos      <= '0;
      run_sum  <= '0;
      hdr_ok   <= 1'b1;
      first_nz <= 1'b0;
      csum     <= '0;
      for (int i = 0; i < RFC_STAGE_DEPTH; i++) begin
        stage[i] <= '0;
      end
    end else if (consume) begin
      if (beat.eop) begin
        pos      <= '0;
        run_sum  <= '0;
        hdr_ok   <= 1'b1;
        first_nz <= 1'b0;
        csum     <= '0;
        for (int i = 0; i < RFC_STAGE_DEPTH; i++) begin
          stage[i] <= '0;
        end
      end else begin
        pos      <= pos_next;
        run_sum  <= sum_next;
        hdr_ok   <= hdr_next;
        first_nz <= first_next;
        csum     <= csum_next;
        stage    <= stage_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_throttle <= '0;
      held_yaw      <= RFC_STICK_RESET;
      held_pitch    <= RFC_STICK_RESET;
      held_roll     <= RFC_STICK_RESET;
      held_altitude <= '0;
      held_shutdown <= '0;
    end else if (held_upd) begin
      held_throttle <= res_data.throttle;
      held_yaw      <= res_data.yaw;
      held_pitch    <= res_data.pitch;
      held_roll     <= res_data.roll;
      held_altitude <= res_data.altitude_cmd;
      held_shutdown <= res_data.shutdown_cmd;
    end
  end

  `RFC_ASSERT(a_pos_bound, clk, rst, pos <= POS_W'(PAYLOAD_BYTES), "position past payload size")
  `RFC_ASSERT_NEXT(a_eop_clear, clk, rst, consume && beat.eop, pos == '0 && run_sum == '0 && hdr_ok, "packet state not cleared after end beat")
  `RFC_ASSERT_NEXT(a_held_stable, clk, rst, !held_upd && !rst, $stable(held_throttle) && $stable(held_yaw) && $stable(held_roll), "held values moved without a valid frame")
  `RFC_ASSERT(a_res_on_eop, clk, rst, !res_vld || (consume && beat.eop), "result without a consumed end beat")

endmodule

/* sv/rfc_out_reg.sv */
// Output register: holds one result beat until the sink takes it.
// Depends on rfc_pkg and rfc_stream_if.
module rfc_out_reg
  import rfc_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         load,
  input  rfc_out_t     data_in,
  rfc_stream_if.source res,
  output logic         out_free
);

  logic     vld;
  rfc_out_t data;

  assign out_free    = !vld || res.ready;
  assign res.valid   = vld;
  assign res.payload = data;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (out_free) begin
      vld <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && load) begin
      data <= data_in;
    end
  end

endmodule
